/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL, included by the deframer top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/ssdf_pkg.sv */
// Types, constants and helpers of the snapshot stream deframer.
package ssdf_pkg;

    localparam int HEADER_LEN    = 21;
    localparam int ENTRY_HDR_LEN = 25;
    localparam int MAGIC_LEN     = 4;

    localparam logic [7:0] CFG_VER_RESET = 8'd1;
    localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h4B, 8'h56, 8'h53, 8'h4E};

    // Byte positions inside the file header and the entry header
    localparam logic [4:0] HDR_VERSION_POS  = 5'(MAGIC_LEN);
    localparam logic [4:0] HDR_BOUNDARY_POS = 5'(MAGIC_LEN + 1 + 8 - 1);
    localparam logic [4:0] HDR_LAST_POS     = 5'(HEADER_LEN - 1);
    localparam logic [4:0] ENT_KEY_POS      = 5'd3;
    localparam logic [4:0] ENT_VALUE_POS    = 5'd7;
    localparam logic [4:0] ENT_VERSION_POS  = 5'd15;
    localparam logic [4:0] ENT_WRITE_ID_POS = 5'd23;
    localparam logic [4:0] ENT_LAST_POS     = 5'(ENTRY_HDR_LEN - 1);

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_META   = 3'd1,
        KIND_KEY    = 3'd2,
        KIND_VALUE  = 3'd3,
        KIND_ERROR  = 3'd4,
        KIND_DONE   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ERR_BAD_HEADER  = 2'd0,
        ERR_BAD_VERSION = 2'd1,
        ERR_ENTRY_CUT   = 2'd2,
        ERR_PAYLOAD_CUT = 2'd3
    } t_err;

    // Queued result; wide fields are shared between header and meta words
    typedef struct packed {
        t_kind       kind;
        logic [63:0] wide_a;    // boundary id / entry version
        logic [63:0] wide_b;    // entry total / write id
        logic [31:0] narrow_a;  // key length
        logic [31:0] narrow_b;  // value length
        logic [7:0]  data;
        logic        flag;      // tombstone / payload last
        t_err        err;
    } t_rec;

    localparam logic [1:0] QPTR_LAST = 2'd2;

    function automatic logic [1:0] qptr_inc(input logic [1:0] p);
        return (p == QPTR_LAST) ? 2'd0 : p + 2'd1;
    endfunction

endpackage

/* hw/rtl/snapshot_stream_deframer_top.sv */
// Snapshot stream deframer: byte parser with a three-word result queue.
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_ready         i_in_byte, i_end_of_file
//  result    out        o_valid / i_ready         o_kind .. o_payload_last
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (expected version)
//
// One input word per cycle while o_ready is high; the parser updates its state in the
// accepting cycle and pushes zero, one or two result words into a three-entry queue.
// Results queue up as their word is accepted; one leaves per cycle with i_ready high.
// o_ready is high while at most one word is queued, so a word yielding two results
// (header+done, meta+done, last payload byte+done, or a result plus an eof error)
// always finds room. Synchronous active-low reset clears parser and queue.
`include "assert_macros.svh"

module snapshot_stream_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_file,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_key_length,
    output logic [31:0] o_value_length,
    output logic [63:0] o_entry_version,
    output logic [63:0] o_entry_write_id,
    output logic        o_tombstone,
    output logic [63:0] o_boundary_id,
    output logic [63:0] o_entry_total,
    output logic [1:0]  o_fault_code,
    output logic        o_payload_last
);
    import ssdf_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ENTRY,
        PH_PAYLOAD,
        PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [63:0] r_shift, n_shift;
    logic [63:0] r_boundary, n_boundary;
    logic [63:0] r_entries, n_entries;
    logic [31:0] r_key, n_key;
    logic [31:0] r_value, n_value;
    logic [32:0] r_payload, n_payload;
    logic [63:0] r_version, n_version;
    logic [63:0] r_write_id, n_write_id;
    logic        r_mismatch, n_mismatch;
    logic [7:0]  r_cfg;

    t_rec        r_q [3];
    logic [1:0]  r_wp, r_rp, r_cnt;

    logic        in_acc, out_pop;
    logic [63:0] shift_nx;
    logic [63:0] entries_dec;
    logic [32:0] payload_sum;
    logic        main_vld, done_vld, eof_vld;
    t_rec        main_rec, done_rec, eof_rec, slot0, slot1, head;
    logic [1:0]  n_res;
    logic        hdr_w, meta_w, pay_w;

    assign o_ready     = (r_cnt <= 2'd1);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign o_valid     = (r_cnt != 2'd0);
    assign out_pop     = o_valid && i_ready;

    assign shift_nx    = {r_shift[55:0], i_in_byte};
    assign entries_dec = r_entries - 64'd1;
    assign payload_sum = {1'b0, r_key} + {1'b0, r_value};

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_shift    = r_shift;
        n_boundary = r_boundary;
        n_entries  = r_entries;
        n_key      = r_key;
        n_value    = r_value;
        n_payload  = r_payload;
        n_version  = r_version;
        n_write_id = r_write_id;
        n_mismatch = r_mismatch;
        main_vld   = 1'b0;
        done_vld   = 1'b0;
        eof_vld    = 1'b0;
        main_rec   = '0;
        done_rec   = '0;
        done_rec.kind = KIND_DONE;
        eof_rec    = '0;
        eof_rec.kind  = KIND_ERROR;

        if (in_acc) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_pos < 5'(MAGIC_LEN)) begin
                        if (i_in_byte != MAGIC[r_pos[1:0]]) begin
                            main_vld      = 1'b1;
                            main_rec.kind = KIND_ERROR;
                            main_rec.err  = ERR_BAD_HEADER;
                            n_phase       = PH_SKIP;
                        end else begin
                            n_pos = r_pos + 5'd1;
                        end
                    end else if (r_pos == HDR_VERSION_POS) begin
                        n_mismatch = (i_in_byte != r_cfg);
                        n_pos      = r_pos + 5'd1;
                    end else begin
                        n_shift = shift_nx;
                        if (r_pos == HDR_BOUNDARY_POS) begin
                            n_boundary = shift_nx;
                        end
                        if (r_pos >= HDR_LAST_POS) begin
                            n_entries = shift_nx;
                            main_vld  = 1'b1;
                            if (r_mismatch) begin
                                main_rec.kind = KIND_ERROR;
                                main_rec.err  = ERR_BAD_VERSION;
                                n_phase       = PH_SKIP;
                            end else begin
                                main_rec.kind   = KIND_HEADER;
                                main_rec.wide_a = r_boundary;
                                main_rec.wide_b = shift_nx;
                                if (shift_nx == 64'd0) begin
                                    done_vld = 1'b1;
                                    n_phase  = PH_SKIP;
                                end else begin
                                    n_phase = PH_ENTRY;
                                    n_pos   = '0;
                                    n_shift = '0;
                                end
                            end
                        end else begin
                            n_pos = r_pos + 5'd1;
                        end
                    end
                end
                PH_ENTRY: begin
                    n_shift = shift_nx;
                    if (r_pos == ENT_KEY_POS) begin
                        n_key = shift_nx[31:0];
                    end else if (r_pos == ENT_VALUE_POS) begin
                        n_value = shift_nx[31:0];
                    end else if (r_pos == ENT_VERSION_POS) begin
                        n_version = shift_nx;
                    end else if (r_pos == ENT_WRITE_ID_POS) begin
                        n_write_id = shift_nx;
                    end
                    if (r_pos >= ENT_LAST_POS) begin
                        main_vld          = 1'b1;
                        main_rec.kind     = KIND_META;
                        main_rec.narrow_a = r_key;
                        main_rec.narrow_b = r_value;
                        main_rec.wide_a   = r_version;
                        main_rec.wide_b   = r_write_id;
                        main_rec.flag     = |i_in_byte;
                        n_payload         = payload_sum;
                        if (payload_sum == 33'd0) begin
                            n_entries = entries_dec;
                            if (entries_dec == 64'd0) begin
                                done_vld = 1'b1;
                                n_phase  = PH_SKIP;
                            end else begin
                                n_phase = PH_ENTRY;
                                n_pos   = '0;
                                n_shift = '0;
                            end
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end else begin
                        n_pos = r_pos + 5'd1;
                    end
                end
                PH_PAYLOAD: begin
                    main_vld      = 1'b1;
                    main_rec.kind = (r_payload > {1'b0, r_value}) ? KIND_KEY : KIND_VALUE;
                    main_rec.data = i_in_byte;
                    main_rec.flag = (r_payload == 33'd1);
                    n_payload     = r_payload - 33'd1;
                    if (r_payload == 33'd1) begin
                        n_entries = entries_dec;
                        if (entries_dec == 64'd0) begin
                            done_vld = 1'b1;
                            n_phase  = PH_SKIP;
                        end else begin
                            n_phase = PH_ENTRY;
                            n_pos   = '0;
                            n_shift = '0;
                        end
                    end
                end
                PH_SKIP: begin
                end
            endcase

            if (i_end_of_file) begin
                eof_vld = (n_phase != PH_SKIP);
                unique case (n_phase)
                    PH_HEADER:  eof_rec.err = ERR_BAD_HEADER;
                    PH_ENTRY:   eof_rec.err = ERR_ENTRY_CUT;
                    PH_PAYLOAD: eof_rec.err = ERR_PAYLOAD_CUT;
                    PH_SKIP:    eof_rec.err = ERR_BAD_HEADER;
                endcase
                n_phase    = PH_HEADER;
                n_pos      = '0;
                n_shift    = '0;
                n_mismatch = 1'b0;
            end
        end
    end

    // At most two of main, done and eof error are valid for one word
    assign n_res = 2'(main_vld) + 2'(done_vld) + 2'(eof_vld);
    assign slot0 = main_vld ? main_rec : (done_vld ? done_rec : eof_rec);
    assign slot1 = (main_vld && done_vld) ? done_rec : eof_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_pos      <= '0;
            r_shift    <= '0;
            r_boundary <= '0;
            r_entries  <= '0;
            r_key      <= '0;
            r_value    <= '0;
            r_payload  <= '0;
            r_version  <= '0;
            r_write_id <= '0;
            r_mismatch <= 1'b0;
            r_cfg      <= CFG_VER_RESET;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_shift    <= n_shift;
            r_boundary <= n_boundary;
            r_entries  <= n_entries;
            r_key      <= n_key;
            r_value    <= n_value;
            r_payload  <= n_payload;
            r_version  <= n_version;
            r_write_id <= n_write_id;
            r_mismatch <= n_mismatch;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (n_res == 2'd1) begin
                r_wp <= qptr_inc(r_wp);
            end else if (n_res == 2'd2) begin
                r_wp <= qptr_inc(qptr_inc(r_wp));
            end
            if (out_pop) begin
                r_rp <= qptr_inc(r_rp);
            end
            r_cnt <= r_cnt + n_res - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res != 2'd0) begin
            r_q[r_wp] <= slot0;
        end
        if (n_res == 2'd2) begin
            r_q[qptr_inc(r_wp)] <= slot1;
        end
    end

    assign head   = r_q[r_rp];
    assign hdr_w  = (head.kind == KIND_HEADER);
    assign meta_w = (head.kind == KIND_META);
    assign pay_w  = (head.kind == KIND_KEY) || (head.kind == KIND_VALUE);

    assign o_kind           = head.kind;
    assign o_data_byte      = pay_w ? head.data : 8'd0;
    assign o_key_length     = meta_w ? head.narrow_a : 32'd0;
    assign o_value_length   = meta_w ? head.narrow_b : 32'd0;
    assign o_entry_version  = meta_w ? head.wide_a : 64'd0;
    assign o_entry_write_id = meta_w ? head.wide_b : 64'd0;
    assign o_tombstone      = meta_w && head.flag;
    assign o_boundary_id    = hdr_w ? head.wide_a : 64'd0;
    assign o_entry_total    = hdr_w ? head.wide_b : 64'd0;
    assign o_fault_code     = (head.kind == KIND_ERROR) ? head.err : ERR_BAD_HEADER;
    assign o_payload_last   = pay_w && head.flag;

    `ASSERT_NEXT(a_eof_rearm, i_clk, i_rst_n, in_acc && i_end_of_file, r_phase == PH_HEADER && r_pos == 5'd0 && !r_mismatch, "eof word did not rearm the parser")
    `ASSERT_ALWAYS(a_payload_due, i_clk, i_rst_n, r_phase != PH_PAYLOAD || r_payload != 33'd0, "payload phase with nothing due")
    `ASSERT_ALWAYS(a_entries_due, i_clk, i_rst_n, r_phase != PH_ENTRY || r_entries != 64'd0, "entry phase with no entries left")
    `ASSERT_ALWAYS(a_header_pos, i_clk, i_rst_n, r_phase != PH_HEADER || r_pos <= HDR_LAST_POS, "header position past header end")
    `ASSERT_NEXT(a_queue_fill, i_clk, i_rst_n, in_acc && !out_pop, r_cnt >= $past(r_cnt), "queue lost a word on accept")

endmodule

/* test/tb.sv */
// Self-checking testbench for the snapshot stream deframer: byte stimulus, prediction, checks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssdf_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 23;

    typedef enum logic [1:0] {P_HEADER, P_ENTRY, P_PAYLOAD, P_SKIP} t_parse_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [31:0] key_len;
        logic [31:0] val_len;
        logic [63:0] ent_ver;
        logic [63:0] ent_wid;
        logic        tomb;
        logic [63:0] bound;
        logic [63:0] total;
        t_err        err;
        logic        last;
    } t_word;

    class deframe_scoreboard;
        t_word        parsed_q[$];
        int unsigned  errors;
        logic [7:0]   want_ver;
        t_parse_phase phase;
        logic [4:0]   pos;
        logic [63:0]  shift_acc, boundary, entries_left, pay_left, ent_ver, ent_wid;
        logic [31:0]  key_len, val_len;
        logic         ver_bad;

        function new();
            errors = 0;
            want_ver = CFG_VER_RESET;
            boundary = '0;
            entries_left = '0;
            pay_left = '0;
            ent_ver = '0;
            ent_wid = '0;
            key_len = '0;
            val_len = '0;
            rearm();
        endfunction

        function void rearm();
            phase = P_HEADER;
            pos = '0;
            shift_acc = '0;
            ver_bad = 1'b0;
        endfunction

        function t_word blank(t_kind k);
            t_word r;
            r = '0;
            r.kind = k;
            return r;
        endfunction

        function void add_word(t_word r);
            parsed_q = {parsed_q, r};
        endfunction

        function void push_error(t_err code);
            t_word r;
            r = blank(KIND_ERROR);
            r.err = code;
            add_word(r);
            phase = P_SKIP;
        endfunction

        function void finish_entry();
            entries_left--;
            if (entries_left == 0) begin
                add_word(blank(KIND_DONE));
                phase = P_SKIP;
            end else begin
                phase = P_ENTRY;
                pos = '0;
                shift_acc = '0;
            end
        endfunction

        function int pending();
            return parsed_q.size();
        endfunction

        // Predicts the result words caused by one accepted input word
        function void note_input(logic [7:0] b, logic eof);
            t_word r;
            case (phase)
                P_HEADER: begin
                    if (pos < MAGIC_LEN) begin
                        if (b != MAGIC[pos[1:0]]) push_error(ERR_BAD_HEADER);
                        else pos++;
                    end else if (pos == HDR_VERSION_POS) begin
                        ver_bad = (b != want_ver);
                        pos++;
                    end else begin
                        shift_acc = {shift_acc[55:0], b};
                        if (pos == HDR_BOUNDARY_POS) boundary = shift_acc;
                        if (pos == HDR_LAST_POS) begin
                            entries_left = shift_acc;
                            if (ver_bad) begin
                                push_error(ERR_BAD_VERSION);
                            end else begin
                                r = blank(KIND_HEADER);
                                r.bound = boundary;
                                r.total = entries_left;
                                add_word(r);
                                if (entries_left == 0) begin
                                    add_word(blank(KIND_DONE));
                                    phase = P_SKIP;
                                end else begin
                                    phase = P_ENTRY;
                                    pos = '0;
                                    shift_acc = '0;
                                end
                            end
                        end else begin
                            pos++;
                        end
                    end
                end
                P_ENTRY: begin
                    shift_acc = {shift_acc[55:0], b};
                    if (pos == ENT_KEY_POS) key_len = shift_acc[31:0];
                    else if (pos == ENT_VALUE_POS) val_len = shift_acc[31:0];
                    else if (pos == ENT_VERSION_POS) ent_ver = shift_acc;
                    else if (pos == ENT_WRITE_ID_POS) ent_wid = shift_acc;
                    if (pos == ENT_LAST_POS) begin
                        r = blank(KIND_META);
                        r.key_len = key_len;
                        r.val_len = val_len;
                        r.ent_ver = ent_ver;
                        r.ent_wid = ent_wid;
                        r.tomb = (b != 8'h00);
                        add_word(r);
                        pay_left = 64'(key_len) + 64'(val_len);
                        if (pay_left == 0) finish_entry();
                        else phase = P_PAYLOAD;
                    end else begin
                        pos++;
                    end
                end
                P_PAYLOAD: begin
                    r = blank((pay_left > 64'(val_len)) ? KIND_KEY : KIND_VALUE);
                    r.data = b;
                    r.last = (pay_left == 1);
                    add_word(r);
                    pay_left--;
                    if (pay_left == 0) finish_entry();
                end
                default: ;
            endcase
            if (eof) begin
                case (phase)
                    P_HEADER:  push_error(ERR_BAD_HEADER);
                    P_ENTRY:   push_error(ERR_ENTRY_CUT);
                    P_PAYLOAD: push_error(ERR_PAYLOAD_CUT);
                    default: ;
                endcase
                rearm();
            end
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_word got);
            t_word want;
            if (parsed_q.size() == 0) begin
                $display("%0t: unexpected result word, kind expected none actual %0d",
                         $time, got.kind);
                errors++;
                return;
            end
            want = parsed_q.pop_front();
            cmp("kind", want.kind, got.kind);
            cmp("data_byte", want.data, got.data);
            cmp("key_length", want.key_len, got.key_len);
            cmp("value_length", want.val_len, got.val_len);
            cmp("entry_version", want.ent_ver, got.ent_ver);
            cmp("entry_write_id", want.ent_wid, got.ent_wid);
            cmp("tombstone", want.tomb, got.tomb);
            cmp("boundary_id", want.bound, got.bound);
            cmp("entry_total", want.total, got.total);
            cmp("fault_code", want.err, got.err);
            cmp("payload_last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_end_of_file = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [31:0] o_key_length;
    logic [31:0] o_value_length;
    logic [63:0] o_entry_version;
    logic [63:0] o_entry_write_id;
    logic        o_tombstone;
    logic [63:0] o_boundary_id;
    logic [63:0] o_entry_total;
    logic [1:0]  o_fault_code;
    logic        o_payload_last;

    deframe_scoreboard sb = new();
    logic [7:0] file_bytes[$];
    logic [7:0] cur_ver = CFG_VER_RESET;
    int         bytes_sent = 0;
    int         rx_hold_cycles = 0;
    bit         tx_idle = 1'b1;
    bit         rx_idle = 1'b1;

    snapshot_stream_deframer_top i_dut (.*);

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_word seen;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.want_ver = i_cfg_data;
            if (i_valid && o_ready) sb.note_input(i_in_byte, i_end_of_file);
            if (o_valid && i_ready) begin
                seen.kind    = t_kind'(o_kind);
                seen.data    = o_data_byte;
                seen.key_len = o_key_length;
                seen.val_len = o_value_length;
                seen.ent_ver = o_entry_version;
                seen.ent_wid = o_entry_write_id;
                seen.tomb    = o_tombstone;
                seen.bound   = o_boundary_id;
                seen.total   = o_entry_total;
                seen.err     = t_err'(o_fault_code);
                seen.last    = o_payload_last;
                sb.check_result(seen);
            end
        end
    end

    // Result side: random stalls plus an optional long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                i_ready <= !(rx_idle && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void put_byte(logic [7:0] b);
        file_bytes = {file_bytes, b};
    endfunction

    function automatic void add_be(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) put_byte(v[8*i +: 8]);
    endfunction

    function automatic void add_header(logic [7:0] ver, logic [63:0] bid, logic [63:0] cnt);
        for (int i = 0; i < MAGIC_LEN; i++) put_byte(MAGIC[i]);
        put_byte(ver);
        add_be(bid, 8);
        add_be(cnt, 8);
    endfunction

    function automatic void add_entry(logic [31:0] kl, logic [31:0] vl, logic [63:0] ev,
                                      logic [63:0] ew, logic [7:0] tomb_byte, int npay);
        add_be(kl, 4);
        add_be(vl, 4);
        add_be(ev, 8);
        add_be(ew, 8);
        put_byte(tomb_byte);
        repeat (npay) put_byte(8'($urandom));
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eof);
        if (tx_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Sends the first cut bytes (the whole file unless 0 < cut < size), end of file on the last
    task automatic send_file(input int cut);
        int n;
        n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
        for (int i = 0; i < n; i++) send_word(file_bytes[i], i == n - 1);
        bytes_sent += n;
        file_bytes.delete();
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_ver = v;
    endtask

    task automatic random_file();
        int sel, n_ent, cut, kl, vl;
        logic [63:0] count;
        sel = $urandom_range(99);
        if (sel < 12) begin
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
            if (sel < 6) file_bytes[0] = MAGIC[0];
            send_file(0);
        end else begin
            n_ent = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3);
            count = ($urandom_range(9) == 0) ? rand64() : 64'(n_ent);
            add_header(($urandom_range(9) == 0) ? 8'($urandom) : cur_ver, rand64(), count);
            repeat (n_ent) begin
                kl = $urandom_range(4);
                vl = $urandom_range(4);
                add_entry(32'(kl), 32'(vl), rand64(), rand64(),
                          $urandom_range(1) ? 8'($urandom) : 8'h00, kl + vl);
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
            cut = (sel < 30) ? $urandom_range(1, file_bytes.size()) : 0;
            send_file(cut);
        end
    endtask

    initial begin
        logic [7:0] v;
        int goal;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bad magic byte at each position
        for (int p = 0; p < MAGIC_LEN; p++) begin
            add_header(cur_ver, rand64(), 64'd1);
            file_bytes[p] = ~file_bytes[p];
            send_file(p + 1 + (p % 2));
        end
        // short header, wrong version, wrong version on a short header
        add_header(cur_ver, rand64(), 64'd1);
        send_file(1);
        add_header(8'h02, rand64(), 64'd1);
        send_file(HEADER_LEN);
        add_header(8'h02, rand64(), 64'd1);
        send_file(12);
        // zero entries with trailing bytes
        add_header(cur_ver, '1, 64'd0);
        repeat (3) put_byte(8'($urandom));
        send_file(0);
        // empty entry with extreme fields
        add_header(cur_ver, '0, 64'd1);
        add_entry(0, 0, '1, '1, 8'hFF, 0);
        send_file(0);

        // no idling on either side through the cut cases
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        add_header(cur_ver, rand64(), 64'd2);
        add_entry(2, 0, rand64(), rand64(), 8'h80, 2);
        add_entry(0, 3, rand64(), rand64(), 8'h01, 3);
        send_file(0);
        // entry header cut: right after the file header, mid header
        add_header(cur_ver, rand64(), 64'd3);
        send_file(0);
        add_header(cur_ver, rand64(), 64'd1);
        add_entry(1, 1, rand64(), rand64(), 8'h00, 2);
        send_file(HEADER_LEN + 10);
        // payload cut in the key, largest lengths
        add_header(cur_ver, rand64(), '1);
        add_entry('1, '1, rand64(), rand64(), 8'h00, 3);
        send_file(0);
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        wait_idle();
        write_cfg(8'h00);
        add_header(8'h00, rand64(), 64'd0);
        send_file(0);
        add_header(CFG_VER_RESET, rand64(), 64'd0);
        send_file(0);
        wait_idle();
        write_cfg(8'hFF);
        // long receiver hold-off while words keep coming
        rx_hold_cycles = 100;
        add_header(8'hFF, rand64(), 64'd1);
        add_entry(2, 2, rand64(), rand64(), 8'h00, 4);
        send_file(0);

        wait_idle();
        v = $urandom_range(1) ? CFG_VER_RESET : 8'($urandom);
        write_cfg(v);
        goal = bytes_sent + 60;
        while (bytes_sent < goal) random_file();

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
